>>> hdl/vtpd_pkg.sv
// Shared constants and lane type for the vertex transform and perspective divide.
`default_nettype none
package vtpd_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int CFG_WIDTH   = 2 * COORD_WIDTH;
    localparam int CFG_COUNT   = 8;
    localparam int CFG_IDX_W   = $clog2(CFG_COUNT);
    localparam int PROD_W      = 2 * COORD_WIDTH;
    localparam int ACC_W       = PROD_W + 2;
    localparam int MAG_W       = PROD_W;
    localparam int QUO_W       = COORD_WIDTH;
    localparam int WIDE_W      = MAG_W + QUO_W;
    localparam int DIV_STEPS   = QUO_W;

    localparam logic [COORD_WIDTH-1:0] ONE = COORD_WIDTH'(1) << FRAC_BITS;

    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [QUO_W-1:0] nq;
        logic             qneg;
        logic             byp;
        logic [QUO_W-1:0] bval;
        logic             bsat;
    } lane_t;

endpackage
`default_nettype wire

>>> hdl/vertex_transform_perspective_divide.sv
// Pipelined 4x4 homogeneous point transform with a bit-per-stage perspective divide.
//
//  channel | ports                  | payload
//  input   | s_tvalid/s_tready      | s_tdata: in_x, in_y, in_z
//  result  | m_tvalid/m_tready      | m_tdata: out_x, out_y, out_z; m_tuser: w_was_zero, saturated
//  config  | cfg_wr_en/cfg_wr_index | cfg_wr_data: one 64-bit matrix register
//
//  One item per cycle while the output register is not held; stages: multiply, sum, magnitude, divide setup,
//  32 restoring divide stages (one quotient bit each), output register.
//  Reset clears the valid bits and loads the identity matrix.
//  The whole pipeline holds while the output register is full and not taken;
//  s_tready is low exactly then.
`default_nettype none
module vertex_transform_perspective_divide (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic [3*vtpd_pkg::COORD_WIDTH-1:0]     s_tdata,   // in_x, in_y, in_z
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [3*vtpd_pkg::COORD_WIDTH-1:0]          m_tdata,   // out_x, out_y, out_z
    output logic [1:0]                                  m_tuser,   // w_was_zero, saturated
    input  wire logic                                   cfg_wr_en,
    input  wire logic [vtpd_pkg::CFG_IDX_W-1:0]         cfg_wr_index,
    input  wire logic [vtpd_pkg::CFG_WIDTH-1:0]         cfg_wr_data
);
    localparam int CW = vtpd_pkg::COORD_WIDTH;
    localparam int FB = vtpd_pkg::FRAC_BITS;
    localparam int PW = vtpd_pkg::PROD_W;
    localparam int AW = vtpd_pkg::ACC_W;
    localparam int MW = vtpd_pkg::MAG_W;
    localparam int QW = vtpd_pkg::QUO_W;
    localparam int DW = vtpd_pkg::WIDE_W;
    localparam int NS = vtpd_pkg::DIV_STEPS;
    localparam logic [MW-1:0] HALF_M = MW'(1) << (CW - 1);
    localparam logic [QW-1:0] HALF_Q = QW'(1) << (CW - 1);

    logic [vtpd_pkg::CFG_WIDTH-1:0] cfg_reg [vtpd_pkg::CFG_COUNT];

    logic                  adv;
    logic signed [CW-1:0]  pin [3];

    logic                  v_prod_reg, v_sum_reg, v_mag_reg;
    logic signed [PW-1:0]  prod_reg [4][3];
    logic signed [CW-1:0]  tr_reg [4];
    logic signed [AW-1:0]  sum_reg [4];
    logic [MW-1:0]         mag_reg [4];
    logic                  neg_reg [4];

    logic                  dv_reg [NS+1];
    logic                  wz_reg [NS+1];
    logic [MW-1:0]         d_reg  [NS+1];
    vtpd_pkg::lane_t       lane_reg  [NS+1][3];
    vtpd_pkg::lane_t       lane_init [3];
    vtpd_pkg::lane_t       lane_next [NS][3];

    logic                  m_tvalid_reg;
    logic [3*CW-1:0]       m_tdata_reg;
    logic [1:0]            m_tuser_reg;
    logic [3*CW-1:0]       tdata_next;
    logic                  sat_next;

    function automatic logic signed [CW-1:0] coef(input int i, input int j);
        logic [vtpd_pkg::CFG_WIDTH-1:0] r;
        r = cfg_reg[2*i + j/2];
        return (j % 2 == 1) ? r[2*CW-1:CW] : r[CW-1:0];
    endfunction

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pin[i] = s_tdata[i*CW +: CW];
        end
    end

    // Configuration: identity after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < vtpd_pkg::CFG_COUNT; r++) begin
                cfg_reg[r] <= '0;
            end
            cfg_reg[0] <= vtpd_pkg::CFG_WIDTH'(vtpd_pkg::ONE);
            cfg_reg[2] <= {vtpd_pkg::ONE, CW'(0)};
            cfg_reg[5] <= vtpd_pkg::CFG_WIDTH'(vtpd_pkg::ONE);
            cfg_reg[7] <= {vtpd_pkg::ONE, CW'(0)};
        end else if (cfg_wr_en) begin
            cfg_reg[cfg_wr_index] <= cfg_wr_data;
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_prod_reg   <= 1'b0;
            v_sum_reg    <= 1'b0;
            v_mag_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k <= NS; k++) begin
                dv_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            v_prod_reg   <= s_tvalid;
            v_sum_reg    <= v_prod_reg;
            v_mag_reg    <= v_sum_reg;
            dv_reg[0]    <= v_mag_reg;
            for (int k = 0; k < NS; k++) begin
                dv_reg[k+1] <= dv_reg[k];
            end
            m_tvalid_reg <= dv_reg[NS];
        end
    end

    // Products, column sums and magnitudes
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < 4; j++) begin
                for (int i = 0; i < 3; i++) begin
                    prod_reg[j][i] <= PW'(pin[i]) * PW'(coef(i, j));
                end
                tr_reg[j]  <= coef(3, j);
                sum_reg[j] <= AW'(prod_reg[j][0]) + AW'(prod_reg[j][1])
                            + AW'(prod_reg[j][2]) + (AW'(tr_reg[j]) <<< FB);
                neg_reg[j] <= sum_reg[j][AW-1];
                mag_reg[j] <= sum_reg[j][AW-1] ? MW'(-sum_reg[j]) : MW'(sum_reg[j]);
            end
        end
    end

    // Divide setup: zero w and quotient overflow bypass the divider
    always_comb begin
        logic          wz;
        logic          ovf;
        logic          zsat;
        logic [MW-1:0] zm;
        logic [MW-1:0] lim;
        logic [DW-1:0] n_ext;
        logic [DW-1:0] d_ext;
        wz = (mag_reg[3] == '0);
        for (int j = 0; j < 3; j++) begin
            n_ext = DW'(mag_reg[j]) << FB;
            d_ext = DW'(mag_reg[3]) << QW;
            ovf   = (n_ext >= d_ext);
            zm    = mag_reg[j] >> FB;
            lim   = neg_reg[j] ? HALF_M : HALF_M - MW'(1);
            zsat  = (zm > lim);
            if (zsat) begin
                zm = lim;
            end
            lane_init[j].rem  = MW'(n_ext >> QW);
            lane_init[j].nq   = n_ext[QW-1:0];
            lane_init[j].qneg = neg_reg[j] ^ neg_reg[3];
            lane_init[j].byp  = wz || ovf;
            if (wz) begin
                lane_init[j].bval = neg_reg[j] ? QW'(-zm) : QW'(zm);
                lane_init[j].bsat = zsat;
            end else begin
                lane_init[j].bval = (neg_reg[j] ^ neg_reg[3]) ? HALF_Q : HALF_Q - QW'(1);
                lane_init[j].bsat = 1'b1;
            end
        end
    end

    // Restoring divide steps, one quotient bit per stage
    always_comb begin
        logic [MW:0] r2;
        logic [MW:0] dd;
        logic        ge;
        for (int k = 0; k < NS; k++) begin
            for (int j = 0; j < 3; j++) begin
                lane_next[k][j] = lane_reg[k][j];
                r2 = {lane_reg[k][j].rem, lane_reg[k][j].nq[QW-1]};
                dd = {1'b0, d_reg[k]};
                ge = (r2 >= dd);
                lane_next[k][j].rem = ge ? MW'(r2 - dd) : MW'(r2);
                lane_next[k][j].nq  = {lane_reg[k][j].nq[QW-2:0], ge};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_reg[0]  <= mag_reg[3];
            wz_reg[0] <= (mag_reg[3] == '0);
            for (int j = 0; j < 3; j++) begin
                lane_reg[0][j] <= lane_init[j];
            end
            for (int k = 0; k < NS; k++) begin
                d_reg[k+1]  <= d_reg[k];
                wz_reg[k+1] <= wz_reg[k];
                for (int j = 0; j < 3; j++) begin
                    lane_reg[k+1][j] <= lane_next[k][j];
                end
            end
        end
    end

    // Final clip of the quotient
    always_comb begin
        logic [QW-1:0] q;
        logic [QW-1:0] lim;
        logic          s;
        sat_next = 1'b0;
        for (int j = 0; j < 3; j++) begin
            q   = lane_reg[NS][j].nq;
            lim = lane_reg[NS][j].qneg ? HALF_Q : HALF_Q - QW'(1);
            s   = (q > lim);
            if (s) begin
                q = lim;
            end
            if (lane_reg[NS][j].byp) begin
                tdata_next[j*CW +: CW] = lane_reg[NS][j].bval;
                sat_next = sat_next | lane_reg[NS][j].bsat;
            end else begin
                tdata_next[j*CW +: CW] = lane_reg[NS][j].qneg ? CW'(-q) : CW'(q);
                sat_next = sat_next | s;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= tdata_next;
            m_tuser_reg <= {sat_next, wz_reg[NS]};
        end
    end

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v_prod_reg)
        else $error("accepted item did not enter the pipeline");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> (v_prod_reg == $past(v_prod_reg)) && (dv_reg[NS] == $past(dv_reg[NS])))
        else $error("pipeline moved during a stall");

    a_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_reg[NS] && !lane_reg[NS][0].byp |-> lane_reg[NS][0].rem < d_reg[NS])
        else $error("divide remainder not below divisor");

    a_wz: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_reg[0] && wz_reg[0] |-> lane_reg[0][0].byp && lane_reg[0][2].byp)
        else $error("zero w did not bypass the divider");

endmodule
`default_nettype wire

>>> sim/tb_vertex_transform_perspective_divide.sv
// Testbench for the vertex transform with perspective divide: self-checking against a local predictor.
`default_nettype none
module tb_vertex_transform_perspective_divide;

    localparam int COORD_WIDTH = vtpd_pkg::COORD_WIDTH;
    localparam int FRAC_BITS   = vtpd_pkg::FRAC_BITS;
    localparam int CFG_WIDTH   = vtpd_pkg::CFG_WIDTH;
    localparam int CFG_COUNT   = vtpd_pkg::CFG_COUNT;
    localparam int CFG_IDX_W   = vtpd_pkg::CFG_IDX_W;
    localparam logic [COORD_WIDTH-1:0] ONE = vtpd_pkg::ONE;

    localparam int LATENCY = 37;
    localparam int CYCLE_LIMIT = 2000000;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0_A = 0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_B = 1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_A = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_B = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_B = 5;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_A = 6;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_B = 7;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] out_x;
        logic [COORD_WIDTH-1:0] out_y;
        logic [COORD_WIDTH-1:0] out_z;
        logic                   w_was_zero;
        logic                   saturated;
    } vertex_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [3*COORD_WIDTH-1:0]     s_tdata;   // in_x, in_y, in_z
    logic                         m_tvalid;
    logic                         m_tready;
    logic [3*COORD_WIDTH-1:0]     m_tdata;   // out_x, out_y, out_z
    logic [1:0]                   m_tuser;   // w_was_zero, saturated
    logic                         cfg_wr_en;
    logic [CFG_IDX_W-1:0]         cfg_wr_index;
    logic [CFG_WIDTH-1:0]         cfg_wr_data;

    logic [CFG_WIDTH-1:0] matrix_regs [CFG_COUNT];
    logic [3*COORD_WIDTH-1:0] points_pending [$];
    vertex_t vertices_due [$];
    int sender_idle_pct;
    int receiver_stall_pct;
    int fail_count;
    int cycle_count;

    vertex_transform_perspective_divide dut (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .cfg_wr_en, .cfg_wr_index, .cfg_wr_data
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic signed [127:0] coefficient(int i, int j);
        logic [CFG_WIDTH-1:0] r;
        logic signed [127:0] c;
        r = matrix_regs[2*i + j/2];
        c = (j % 2) ? $signed(r[63:32]) : $signed(r[31:0]);
        return c;
    endfunction

    function automatic logic [COORD_WIDTH-1:0] clip_coord(logic [127:0] q, logic neg,
                                                           inout logic sat);
        logic [127:0] limit;
        limit = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (q > limit) begin
            q = limit;
            sat = 1'b1;
        end
        return neg ? -q[31:0] : q[31:0];
    endfunction

    function automatic vertex_t transform_point(logic [3*COORD_WIDTH-1:0] d);
        logic signed [127:0] p [3];
        logic signed [127:0] col;
        logic [127:0] mag [4];
        logic neg [4];
        logic [COORD_WIDTH-1:0] o [3];
        logic sat;
        vertex_t v;
        for (int i = 0; i < 3; i++) p[i] = $signed(d[32*i +: 32]);
        for (int j = 0; j < 4; j++) begin
            col = coefficient(3, j) <<< FRAC_BITS;
            for (int i = 0; i < 3; i++) col += p[i] * coefficient(i, j);
            neg[j] = col[127];
            mag[j] = neg[j] ? -col : col;
        end
        sat = 1'b0;
        for (int j = 0; j < 3; j++) begin
            if (mag[3] == 0)
                o[j] = clip_coord(mag[j] >> FRAC_BITS, neg[j], sat);
            else
                o[j] = clip_coord((mag[j] << FRAC_BITS) / mag[3], neg[j] ^ neg[3], sat);
        end
        v.out_x = o[0];
        v.out_y = o[1];
        v.out_z = o[2];
        v.w_was_zero = (mag[3] == 0);
        v.saturated = sat;
        return v;
    endfunction

    // drive the input channel from the pending queue
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (points_pending.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata <= points_pending.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // predict on acceptance, check on delivery
    always @(posedge aclk) begin
        vertex_t exp_v;
        if (aresetn && s_tvalid && s_tready)
            vertices_due.push_back(transform_point(s_tdata));
        if (aresetn && m_tvalid && m_tready) begin
            if (vertices_due.size() == 0) begin
                $error("unexpected vertex: data %h user %b", m_tdata, m_tuser);
                fail_count++;
            end else begin
                exp_v = vertices_due.pop_front();
                if (m_tdata[31:0] !== exp_v.out_x) begin
                    $error("out_x expected %h actual %h", exp_v.out_x, m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[63:32] !== exp_v.out_y) begin
                    $error("out_y expected %h actual %h", exp_v.out_y, m_tdata[63:32]);
                    fail_count++;
                end
                if (m_tdata[95:64] !== exp_v.out_z) begin
                    $error("out_z expected %h actual %h", exp_v.out_z, m_tdata[95:64]);
                    fail_count++;
                end
                if (m_tuser[0] !== exp_v.w_was_zero) begin
                    $error("w_was_zero expected %b actual %b", exp_v.w_was_zero, m_tuser[0]);
                    fail_count++;
                end
                if (m_tuser[1] !== exp_v.saturated) begin
                    $error("saturated expected %b actual %b", exp_v.saturated, m_tuser[1]);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic drain();
        while (points_pending.size() > 0 || s_tvalid || vertices_due.size() > 0)
            @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // write a full matrix; hold enable across consecutive writes
    task automatic load_matrix(logic [CFG_WIDTH-1:0] vals [CFG_COUNT]);
        for (int k = 0; k < CFG_COUNT; k++) begin
            @(posedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_wr_index <= k[CFG_IDX_W-1:0];
            cfg_wr_data <= vals[k];
            matrix_regs[k] = vals[k];
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(4))
            0: return $urandom;
            1: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
            2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            3: return $urandom_range(1) ? ONE : -ONE;
            default: return '0;
        endcase
    endfunction

    function automatic logic [3*COORD_WIDTH-1:0] random_point();
        return {random_word(), random_word(), random_word()};
    endfunction

    task automatic set_idling(int phase);
        case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 73; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 73; end
            default: begin sender_idle_pct = 12; receiver_stall_pct = 12; end
        endcase
    endtask

    task automatic directed_points();
        logic [31:0] edge_vals [6];
        edge_vals = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h1, 32'hffff_ffff, ONE};
        foreach (edge_vals[k])
            points_pending.push_back({edge_vals[k], edge_vals[(k+1)%6], edge_vals[(k+2)%6]});
    endtask

    initial begin
        logic [CFG_WIDTH-1:0] m [CFG_COUNT];
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_index = '0;
        cfg_wr_data = '0;
        fail_count = 0;
        cycle_count = 0;
        matrix_regs = '{default: '0};
        matrix_regs[REG_ROW0_A] = CFG_WIDTH'(ONE);
        matrix_regs[REG_ROW1_A] = {ONE, 32'h0};
        matrix_regs[REG_ROW2_B] = CFG_WIDTH'(ONE);
        matrix_regs[REG_ROW3_B] = {ONE, 32'h0};
        set_idling(0);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // identity after reset
        directed_points();
        drain();

        // tiny w: m33 is one lsb
        m = matrix_regs;
        m[REG_ROW3_B] = {32'h1, 32'h0};
        load_matrix(m);
        set_idling(1);
        directed_points();
        drain();

        // zero w: no divide, flag raised
        m[REG_ROW3_B] = {32'h0, 32'h0003_8000};
        m[REG_ROW3_A] = {32'hfffe_0000, 32'h0001_4000};
        load_matrix(m);
        set_idling(2);
        directed_points();
        drain();

        // extreme coefficients
        foreach (m[k]) m[k] = 64'h7fff_ffff_7fff_ffff;
        load_matrix(m);
        set_idling(3);
        directed_points();
        drain();
        foreach (m[k]) m[k] = 64'h8000_0000_8000_0000;
        load_matrix(m);
        directed_points();
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            foreach (m[k]) m[k] = {random_word(), random_word()};
            // keep w identically zero now and then
            if (ph % 3 == 2) begin
                m[REG_ROW0_B][63:32] = '0;
                m[REG_ROW1_B][63:32] = '0;
                m[REG_ROW2_B][63:32] = '0;
                m[REG_ROW3_B][63:32] = '0;
            end
            load_matrix(m);
            set_idling(ph);
            for (int n = 0; n < 100; n++) points_pending.push_back(random_point());
            if (ph == 4) begin
                // hold off until the pipeline is empty
                while (points_pending.size() > 0 || s_tvalid || vertices_due.size() > 0)
                    @(posedge aclk);
            end
            for (int n = 0; n < 100; n++) points_pending.push_back(random_point());
            drain();
        end

        if (vertices_due.size() != 0) fail_count++;
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire
